// ----- rtl/core/ild_pkg.sv -----
package ild_pkg;

	// Architectural limit on the length of one instruction, in bytes.
	localparam int MAX_INSTR_LEN = 15;

	// Opcode and prefix bytes that the parser treats specially.
	localparam logic [7:0] OPSZ_PREFIX = 8'h66;
	localparam logic [7:0] ADSZ_PREFIX = 8'h67;
	localparam logic [7:0] ESC_0F      = 8'h0F;
	localparam logic [7:0] ESC_38      = 8'h38;
	localparam logic [7:0] ESC_3A      = 8'h3A;
	localparam logic [7:0] OP_GRP1_IZ  = 8'h81;
	localparam logic [7:0] REX_W_BIT   = 8'h08;
	localparam logic [7:0] LOCK_PREFIX = 8'hF0;
	localparam logic [7:0] REX_LO      = 8'h40;
	localparam logic [7:0] REX_HI      = 8'h4F;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PREFIX,
		PH_ESC,
		PH_ESC3,
		PH_MODRM,
		PH_TAIL
	} phase_t;

	typedef enum logic [1:0] {
		SZ16,
		SZ32,
		SZ64
	} sz_t;

	// One code byte word and one length result word.
	typedef struct packed {
		logic [7:0] code_byte;
		logic       start_req;
	} code_word_t;

	typedef struct packed {
		logic [3:0] instr_length;
		logic       invalid;
	} len_word_t;

	// Parser state carried from one byte to the next.
	typedef struct packed {
		phase_t     phase;
		logic [4:0] byte_count;
		sz_t        opsz;
		sz_t        adsz;
		logic [3:0] pend_imm;
		logic [3:0] bytes_rem;
	} ild_state_t;

	// Result of the opcode class lookup.
	typedef struct packed {
		logic       modrm;
		logic [3:0] imm;
	} op_class_t;

	// Prefix bytes; REX counts only in long mode.
	function automatic logic is_prefix(input logic [7:0] b, input logic lm);
		logic r;
		r = 1'b0;
		unique case (b) inside
			LOCK_PREFIX, 8'hF2, 8'hF3, 8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65,
			OPSZ_PREFIX, ADSZ_PREFIX: r = 1'b1;
			default: r = lm && (b >= REX_LO) && (b <= REX_HI);
		endcase
		return r;
	endfunction

	// Simplified opcode class table: ModR/M need and immediate size.
	function automatic op_class_t op_class(input logic [7:0] op, input sz_t opsz);
		op_class_t c;
		c = '{modrm: 1'b1, imm: 4'd0};
		unique case (op) inside
			[8'h50:8'h5F], 8'h90, 8'hC3, 8'hC9, 8'hF4, 8'hCC: begin
				c = '{modrm: 1'b0, imm: 4'd0};
			end
			8'hEB, [8'h70:8'h7F], [8'hB0:8'hB7]: begin
				c = '{modrm: 1'b0, imm: 4'd1};
			end
			8'hE8, 8'hE9, [8'hB8:8'hBF]: begin
				c = '{modrm: 1'b0, imm: 4'd4};
			end
			[8'h80:8'h83]: begin
				if (op == OP_GRP1_IZ) begin
					c.imm = (opsz == SZ16) ? 4'd2 : (opsz == SZ64) ? 4'd8 : 4'd4;
				end else begin
					c.imm = 4'd1;
				end
			end
			default: c = '{modrm: 1'b1, imm: 4'd0};
		endcase
		return c;
	endfunction

	// Displacement and SIB bytes that follow a ModR/M byte.
	function automatic logic [2:0] modrm_extra(input logic [7:0] m, input sz_t adsz);
		logic [1:0] md;
		logic [2:0] rm;
		logic [2:0] n;
		md = m[7:6];
		rm = m[2:0];
		n  = 3'd0;
		if (adsz == SZ16) begin
			if (md == 2'd0 && rm == 3'd6) n = 3'd2;
			else if (md == 2'd1) n = 3'd1;
			else if (md == 2'd2) n = 3'd2;
		end else begin
			if (md == 2'd0 && rm == 3'd5) n = 3'd4;
			else if (md == 2'd1) n = 3'd1;
			else if (md == 2'd2) n = 3'd4;
			if (md != 2'd3 && rm == 3'd4) n = n + 3'd1;
		end
		return n;
	endfunction

endpackage

// ----- rtl/core/ild_step.sv -----
module ild_step import ild_pkg::*; (
	input  ild_state_t st,
	input  code_word_t word,
	input  logic       long_mode,
	output ild_state_t st_nxt,
	output logic       emit,
	output len_word_t  result
);

	ild_state_t cur;
	logic [7:0] b;
	logic [7:0] op;
	logic [4:0] bc1;
	logic [3:0] br1;
	logic       isp;
	logic       is_esc3;
	logic       lim_ge;
	logic       lim_gt;
	op_class_t  cls;
	logic [2:0] ext;
	logic [5:0] fin_total;
	logic [3:0] fin_rest;
	logic       fin_over;
	phase_t     fin_phase;
	phase_t     class_phase;
	phase_t     nxt_phase;
	logic       bad;
	logic [3:0] len;

	// Common decode of the current byte, after a start has reset the parser.
	always_comb begin
		cur = st;
		if (word.start_req) begin
			cur.phase      = PH_PREFIX;
			cur.byte_count = 5'd0;
			cur.opsz       = SZ32;
			cur.adsz       = long_mode ? SZ64 : SZ32;
			cur.pend_imm   = 4'd0;
			cur.bytes_rem  = 4'd0;
		end
		b       = word.code_byte;
		bc1     = cur.byte_count + 5'd1;
		br1     = cur.bytes_rem - 4'd1;
		isp     = is_prefix(b, long_mode);
		is_esc3 = (b == ESC_38) || (b == ESC_3A);
		lim_ge  = bc1 >= 5'(MAX_INSTR_LEN);
		lim_gt  = bc1 > 5'(MAX_INSTR_LEN);
		op      = (cur.phase == PH_ESC3) ? ESC_38 : b;
		cls     = op_class(op, cur.opsz);
		ext     = modrm_extra(b, cur.adsz);
		if (cur.phase == PH_MODRM) begin
			fin_rest  = {1'b0, ext} + cur.pend_imm;
		end else begin
			fin_rest  = cls.imm;
		end
		fin_total   = {1'b0, bc1} + {2'b00, fin_rest};
		fin_over    = fin_total > 6'(MAX_INSTR_LEN);
		fin_phase   = (fin_over || fin_rest == 4'd0) ? PH_IDLE : PH_TAIL;
		if (cls.modrm) begin
			class_phase = lim_ge ? PH_IDLE : PH_MODRM;
		end else begin
			class_phase = fin_phase;
		end
	end

	// Next parse phase.
	always_comb begin
		nxt_phase = PH_IDLE;
		unique case (cur.phase)
			PH_IDLE: nxt_phase = PH_IDLE;
			PH_PREFIX: begin
				if (isp) nxt_phase = lim_gt ? PH_IDLE : PH_PREFIX;
				else if (b == ESC_0F) nxt_phase = lim_ge ? PH_IDLE : PH_ESC;
				else nxt_phase = class_phase;
			end
			PH_ESC: begin
				if (is_esc3) nxt_phase = lim_ge ? PH_IDLE : PH_ESC3;
				else nxt_phase = class_phase;
			end
			PH_ESC3:  nxt_phase = class_phase;
			PH_MODRM: nxt_phase = fin_phase;
			PH_TAIL:  nxt_phase = (br1 == 4'd0) ? PH_IDLE : PH_TAIL;
			default:  nxt_phase = PH_IDLE;
		endcase
	end

	// Result and the data part of the state.
	always_comb begin
		st_nxt       = cur;
		st_nxt.phase = nxt_phase;
		emit         = 1'b0;
		bad          = 1'b0;
		len          = fin_total[3:0];
		unique case (cur.phase)
			PH_IDLE: begin
				st_nxt = cur;
			end
			PH_PREFIX, PH_ESC, PH_ESC3, PH_MODRM: begin
				st_nxt.byte_count = bc1;
				if (cur.phase == PH_PREFIX && isp) begin
					if (b == OPSZ_PREFIX) st_nxt.opsz = SZ16;
					if (b == ADSZ_PREFIX) st_nxt.adsz = (cur.adsz == SZ64) ? SZ32 : SZ16;
					if (long_mode && b >= REX_LO && b <= REX_HI && (b & REX_W_BIT) != 8'd0) begin
						st_nxt.opsz = SZ64;
					end
					if (lim_gt) begin
						emit = 1'b1;
						bad  = 1'b1;
					end
				end else if ((cur.phase == PH_PREFIX && b == ESC_0F) ||
				             (cur.phase == PH_ESC && is_esc3)) begin
					if (lim_ge) begin
						emit = 1'b1;
						bad  = 1'b1;
					end
				end else if (cur.phase != PH_MODRM && cls.modrm) begin
					if (lim_ge) begin
						emit = 1'b1;
						bad  = 1'b1;
					end else begin
						st_nxt.pend_imm = cls.imm;
					end
				end else begin
					// Length is now known: finish, or wait for the tail bytes.
					if (fin_over) begin
						emit = 1'b1;
						bad  = 1'b1;
					end else if (fin_rest == 4'd0) begin
						emit = 1'b1;
					end else begin
						st_nxt.bytes_rem = fin_rest;
						st_nxt.pend_imm  = 4'd0;
					end
				end
			end
			PH_TAIL: begin
				st_nxt.byte_count = bc1;
				st_nxt.bytes_rem  = br1;
				if (br1 == 4'd0) begin
					emit = 1'b1;
					len  = bc1[3:0];
				end
			end
			default: begin
				st_nxt = cur;
			end
		endcase
		if (emit) begin
			st_nxt.pend_imm  = 4'd0;
			st_nxt.bytes_rem = 4'd0;
		end
		result.instr_length = bad ? 4'd0 : len;
		result.invalid      = bad;
	end

endmodule

// ----- rtl/core/x86_instruction_length_decoder.sv -----
// Streaming x86 instruction length decoder.
// Code words (one byte plus a start flag) enter on the code channel with
// code_valid/code_ready; lengths leave on the len channel with
// len_valid/len_ready. A word with start_req set begins a new instruction and
// drops any partial one. A result word is produced on the last byte of an
// instruction, or at once when a 15-byte limit is broken (invalid set, length
// zero); other bytes produce nothing. Bytes seen while idle are dropped.
// Throughput: one byte per cycle unless the receiver stalls; the parser state
// update is a single registered step, so no byte waits on the one before it.
// When the receiver stalls, the pending result is held and the input stage
// fills, after which code_ready drops until len_ready returns.
// long_mode is written through cfg_we/cfg_data; the user must do so only
// while the decoder is idle, as the block itself does not enforce this.
// Reset clears the parser to idle, empties both stages and clears long_mode.
module x86_instruction_length_decoder import ild_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_data,
	input  logic       code_valid,
	output logic       code_ready,
	input  code_word_t code_word,
	output logic       len_valid,
	input  logic       len_ready,
	output len_word_t  len_word
);

	logic       long_mode_q;
	code_word_t code_s1;
	logic       code_valid_s1;
	ild_state_t st_q;
	ild_state_t st_nxt;
	logic       step_emit;
	len_word_t  step_result;
	len_word_t  len_q;
	logic       len_valid_q;
	logic       advance;

	// The parsed byte moves on whenever the result register can take a word.
	assign advance    = code_valid_s1 && (!len_valid_q || len_ready);
	assign code_ready = !code_valid_s1 || advance;
	assign len_valid  = len_valid_q;
	assign len_word   = len_q;

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) long_mode_q <= 1'b0;
		else if (cfg_we) long_mode_q <= cfg_data;
	end

	// Input stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) code_valid_s1 <= 1'b0;
		else if (code_ready) code_valid_s1 <= code_valid;
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (code_valid && code_ready) code_s1 <= code_word;
	end

	// Parse step between the input stage and the result register.
	ild_step u_step (
		.st        (st_q),
		.word      (code_s1),
		.long_mode (long_mode_q),
		.st_nxt    (st_nxt),
		.emit      (step_emit),
		.result    (step_result)
	);

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase      <= PH_IDLE;
			st_q.byte_count <= 5'd0;
			st_q.opsz       <= SZ32;
			st_q.adsz       <= SZ32;
			st_q.pend_imm   <= 4'd0;
			st_q.bytes_rem  <= 4'd0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// Result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) len_valid_q <= 1'b0;
		else if (advance && step_emit) len_valid_q <= 1'b1;
		else if (len_ready) len_valid_q <= 1'b0;
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance && step_emit) len_q <= step_result;
	end

`ifndef SYNTHESIS
	// An invalid result carries a zero length.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		len_valid && len_word.invalid |-> len_word.instr_length == 4'd0)
		else $error("invalid result with nonzero length");

	// A good result is never of zero length.
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		len_valid && !len_word.invalid |-> len_word.instr_length != 4'd0)
		else $error("valid result with zero length");

	// After a result the parser is idle.
	a_idle_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_emit |=> st_q.phase == PH_IDLE)
		else $error("parser not idle after a result");

	// The tail phase always has bytes left to take.
	a_tail_count: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_TAIL |-> st_q.bytes_rem != 4'd0)
		else $error("tail phase with no bytes remaining");
`endif

endmodule

// ----- tb/tb_top.sv -----
module tb_top import ild_pkg::*; ();

	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 4;
	localparam int PHASE_WORDS  = 250;
	localparam int PHASES       = 8;
	localparam int PLAN_ROWS    = 25;

	// One row of the directed plan: a code word, and a typed result where one is fixed.
	typedef struct packed {
		logic [7:0] code_byte;
		logic       start_req;
		logic       fixed;
		logic [3:0] instr_length;
		logic       invalid;
	} plan_row_t;

	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{8'hFF, 1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h90, 1'b1, 1'b1, 4'd1, 1'b0},
		'{8'hEB, 1'b1, 1'b0, 4'd0, 1'b0},
		'{8'h80, 1'b0, 1'b1, 4'd2, 1'b0},
		'{8'hE8, 1'b1, 1'b0, 4'd0, 1'b0},
		'{8'h11, 1'b0, 1'b0, 4'd0, 1'b0},
		'{8'hCC, 1'b1, 1'b1, 4'd1, 1'b0},
		'{LOCK_PREFIX, 1'b1, 1'b0, 4'd0, 1'b0},
		'{OPSZ_PREFIX, 1'b0, 1'b0, 4'd0, 1'b0},
		'{ADSZ_PREFIX, 1'b0, 1'b0, 4'd0, 1'b0},
		'{8'hF2, 1'b0, 1'b0, 4'd0, 1'b0},
		'{8'hF3, 1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h26, 1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h2E, 1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h36, 1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h3E, 1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h64, 1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h65, 1'b0, 1'b0, 4'd0, 1'b0},
		'{LOCK_PREFIX, 1'b0, 1'b0, 4'd0, 1'b0},
		'{OPSZ_PREFIX, 1'b0, 1'b0, 4'd0, 1'b0},
		'{ADSZ_PREFIX, 1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h2E, 1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h3E, 1'b0, 1'b1, 4'd0, 1'b1},
		'{8'h00, 1'b1, 1'b0, 4'd0, 1'b0},
		'{8'h00, 1'b0, 1'b1, 4'd2, 1'b0}
	};

	localparam logic [7:0] LEGACY_PREFIXES [11] = '{
		LOCK_PREFIX, 8'hF2, 8'hF3, 8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65,
		OPSZ_PREFIX, ADSZ_PREFIX
	};

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_data;
	logic       code_valid;
	logic       code_ready;
	code_word_t code_word;
	logic       len_valid;
	logic       len_ready;
	len_word_t  len_word;

	// Decoder state as the testbench tracks it.
	logic       mode_long;
	phase_t     ild_phase;
	logic [4:0] ild_count;
	sz_t        ild_opsz;
	sz_t        ild_adsz;
	logic [3:0] ild_imm;
	logic [3:0] ild_rem;

	len_word_t length_q [$];
	int        mismatch_count;
	int        word_count;
	int        stall_cycles;
	int        tx_max_gap;
	int        rx_max_gap;
	int        rx_hold;

	x86_instruction_length_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.code_valid(code_valid),
		.code_ready(code_ready),
		.code_word (code_word),
		.len_valid (len_valid),
		.len_ready (len_ready),
		.len_word  (len_word)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Prefix bytes; REX bytes count only in long mode.
	function automatic bit is_prefix_byte(input logic [7:0] b);
		foreach (LEGACY_PREFIXES[i]) begin
			if (b == LEGACY_PREFIXES[i]) return 1'b1;
		end
		return mode_long && b >= REX_LO && b <= REX_HI;
	endfunction

	// Opcode class: whether a ModR/M byte follows and how many immediate bytes.
	function automatic void op_shape(input logic [7:0] op, output bit modrm, output int imm);
		modrm = 1'b0;
		imm   = 0;
		if ((op >= 8'h50 && op <= 8'h5F) || op == 8'h90 || op == 8'hC3 || op == 8'hC9 ||
		    op == 8'hF4 || op == 8'hCC) begin
			imm = 0;
		end else if (op == 8'hEB || (op >= 8'h70 && op <= 8'h7F) ||
		             (op >= 8'hB0 && op <= 8'hB7)) begin
			imm = 1;
		end else if (op == 8'hE8 || op == 8'hE9 || (op >= 8'hB8 && op <= 8'hBF)) begin
			imm = 4;
		end else begin
			modrm = 1'b1;
			if (op == OP_GRP1_IZ) begin
				imm = (ild_opsz == SZ16) ? 2 : (ild_opsz == SZ64) ? 8 : 4;
			end else if (op >= 8'h80 && op <= 8'h83) begin
				imm = 1;
			end
		end
	endfunction

	// Displacement and SIB bytes implied by a ModR/M byte at the current address size.
	function automatic int disp_bytes(input logic [7:0] m);
		int n;
		n = 0;
		if (ild_adsz == SZ16) begin
			if (m[7:6] == 2'd0 && m[2:0] == 3'd6) n = 2;
			else if (m[7:6] == 2'd1) n = 1;
			else if (m[7:6] == 2'd2) n = 2;
		end else begin
			if (m[7:6] == 2'd0 && m[2:0] == 3'd5) n = 4;
			else if (m[7:6] == 2'd1) n = 1;
			else if (m[7:6] == 2'd2) n = 4;
			if (m[7:6] != 2'd3 && m[2:0] == 3'd4) n = n + 1;
		end
		return n;
	endfunction

	// Close the instruction with a length word and return to idle.
	task automatic close_instr(input logic [3:0] len, input logic bad, output bit got,
	                           output len_word_t lw);
		got             = 1'b1;
		lw.instr_length = bad ? 4'd0 : len;
		lw.invalid      = bad;
		ild_phase       = PH_IDLE;
		ild_rem         = '0;
		ild_imm         = '0;
	endtask

	// Total length known: either over the limit, complete, or waiting on tail bytes.
	task automatic settle_length(input int total, input int rest, output bit got,
	                             output len_word_t lw);
		if (total > MAX_INSTR_LEN) begin
			close_instr(4'd0, 1'b1, got, lw);
		end else if (rest == 0) begin
			close_instr(total[3:0], 1'b0, got, lw);
		end else begin
			ild_rem   = rest[3:0];
			ild_imm   = '0;
			ild_phase = PH_TAIL;
		end
	endtask

	task automatic take_opcode(input logic [7:0] op, output bit got, output len_word_t lw);
		bit modrm;
		int imm;
		op_shape(op, modrm, imm);
		if (!modrm) begin
			settle_length(int'(ild_count) + imm, imm, got, lw);
		end else if (ild_count >= MAX_INSTR_LEN) begin
			close_instr(4'd0, 1'b1, got, lw);
		end else begin
			ild_imm   = imm[3:0];
			ild_phase = PH_MODRM;
		end
	endtask

	// Advance the tracked decoder by one code word; got says whether a length word results.
	task automatic decode_byte(input logic [7:0] b, input logic st, output bit got,
	                           output len_word_t lw);
		int extra;
		got = 1'b0;
		lw  = '0;
		if (st) begin
			ild_phase = PH_PREFIX;
			ild_count = '0;
			ild_opsz  = SZ32;
			ild_adsz  = mode_long ? SZ64 : SZ32;
			ild_imm   = '0;
			ild_rem   = '0;
		end
		case (ild_phase)
			PH_PREFIX: begin
				ild_count = ild_count + 5'd1;
				if (is_prefix_byte(b)) begin
					if (b == OPSZ_PREFIX) ild_opsz = SZ16;
					if (b == ADSZ_PREFIX) ild_adsz = (ild_adsz == SZ64) ? SZ32 : SZ16;
					if (mode_long && b >= REX_LO && b <= REX_HI && (b & REX_W_BIT) != 0)
						ild_opsz = SZ64;
					if (ild_count > MAX_INSTR_LEN) close_instr(4'd0, 1'b1, got, lw);
				end else if (b == ESC_0F) begin
					if (ild_count >= MAX_INSTR_LEN) close_instr(4'd0, 1'b1, got, lw);
					else ild_phase = PH_ESC;
				end else begin
					take_opcode(b, got, lw);
				end
			end
			PH_ESC: begin
				ild_count = ild_count + 5'd1;
				if (b == ESC_38 || b == ESC_3A) begin
					if (ild_count >= MAX_INSTR_LEN) close_instr(4'd0, 1'b1, got, lw);
					else ild_phase = PH_ESC3;
				end else begin
					take_opcode(b, got, lw);
				end
			end
			PH_ESC3: begin
				ild_count = ild_count + 5'd1;
				take_opcode(ESC_38, got, lw);
			end
			PH_MODRM: begin
				ild_count = ild_count + 5'd1;
				extra = disp_bytes(b);
				settle_length(int'(ild_count) + extra + int'(ild_imm), extra + int'(ild_imm),
				              got, lw);
			end
			PH_TAIL: begin
				ild_count = ild_count + 5'd1;
				ild_rem   = ild_rem - 4'd1;
				if (ild_rem == 4'd0) close_instr(ild_count[3:0], 1'b0, got, lw);
			end
			default: begin
			end
		endcase
	endtask

	// Offer one code word after a random gap and track it once it is accepted.
	task automatic put_byte(input logic [7:0] b, input logic st, input logic fixed,
	                        input len_word_t want);
		int        gap;
		bit        got;
		len_word_t lw;
		gap = $urandom_range(0, tx_max_gap);
		if (gap > 0) begin
			@(negedge clk);
			code_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		code_valid = 1'b1;
		code_word  = '{code_byte: b, start_req: st};
		do @(posedge clk); while (!code_ready);
		if (st || ild_phase != PH_IDLE) word_count++;
		decode_byte(b, st, got, lw);
		if (fixed) length_q.push_back(want);
		else if (got) length_q.push_back(lw);
	endtask

	// One instruction: mostly well formed with random content, sometimes cut short or noise.
	task automatic random_instr();
		int         npre;
		int         steps;
		int         cap;
		int         esc;
		logic       lead;
		logic [7:0] op;
		if ($urandom_range(0, 9) == 0) begin
			put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0, '0);
			return;
		end
		lead = 1'b1;
		npre = ($urandom_range(0, 6) == 0) ? $urandom_range(10, 16) : $urandom_range(0, 3);
		for (int i = 0; i < npre; i++) begin
			if ($urandom_range(0, 3) == 0)
				op = REX_LO + 8'($urandom_range(0, 15));
			else
				op = LEGACY_PREFIXES[$urandom_range(0, 10)];
			put_byte(op, lead, 1'b0, '0);
			lead = 1'b0;
		end
		esc = $urandom_range(0, 7);
		if (esc <= 2) begin
			put_byte(ESC_0F, lead, 1'b0, '0);
			lead = 1'b0;
			if (esc == 1) put_byte(ESC_38, 1'b0, 1'b0, '0);
			if (esc == 2) put_byte(ESC_3A, 1'b0, 1'b0, '0);
		end
		case ($urandom_range(0, 3))
			0: op = 8'h80 + 8'($urandom_range(0, 3));
			1: op = OP_GRP1_IZ;
			default: op = 8'($urandom_range(0, 255));
		endcase
		put_byte(op, lead, 1'b0, '0);
		// Remaining bytes are random; an occasional cap can leave the instruction unfinished.
		cap   = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 3) : 24;
		steps = 0;
		while (ild_phase != PH_IDLE && steps < cap) begin
			put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
			steps++;
		end
	endtask

	// Stop offering words, wait for every expected length word, then let the decoder settle.
	task automatic drain();
		@(negedge clk);
		code_valid = 1'b0;
		while (length_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(input logic m);
		drain();
		cfg_we   = 1'b1;
		cfg_data = m;
		@(negedge clk);
		cfg_we    = 1'b0;
		mode_long = m;
	endtask

	task automatic flag_mismatch(input string what, input len_word_t want, input len_word_t seen);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s: expected length %0d invalid %0b, got length %0d invalid %0b",
			         $time, what, want.instr_length, want.invalid, seen.instr_length,
			         seen.invalid);
	endtask

	// Length words are checked in order against the expected ones.
	always @(posedge clk) begin
		len_word_t want;
		if (arst_n && len_valid && len_ready) begin
			if (length_q.size() == 0) begin
				flag_mismatch("unexpected length word", '0, len_word);
			end else begin
				want = length_q.pop_front();
				if (len_word.instr_length !== want.instr_length ||
				    len_word.invalid !== want.invalid)
					flag_mismatch("length word mismatch", want, len_word);
			end
			rx_hold = $urandom_range(0, rx_max_gap);
		end
	end

	// Receiver holds ready low for the stall drawn after each length word.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			len_ready = 1'b0;
			rx_hold   = rx_hold - 1;
		end else begin
			len_ready = 1'b1;
		end
	end

	// Watchdog on cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if ((code_valid && code_ready) || (len_valid && len_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles = stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_data       = 1'b0;
		code_valid     = 1'b0;
		code_word      = '0;
		len_ready      = 1'b0;
		rx_hold        = 0;
		stall_cycles   = 0;
		mismatch_count = 0;
		word_count     = 0;
		tx_max_gap     = 5;
		rx_max_gap     = 5;
		mode_long      = 1'b0;
		ild_phase      = PH_IDLE;
		ild_count      = '0;
		ild_opsz       = SZ32;
		ild_adsz       = SZ32;
		ild_imm        = '0;
		ild_rem        = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed plan in legacy mode.
		write_mode(1'b0);
		for (int i = 0; i < PLAN_ROWS; i++) begin
			put_byte(PLAN[i].code_byte, PLAN[i].start_req, PLAN[i].fixed,
			         '{instr_length: PLAN[i].instr_length, invalid: PLAN[i].invalid});
		end

		// Random phases alternate the mode; some run with no idling on either side.
		for (int ph = 0; ph < PHASES; ph++) begin
			write_mode(ph % 2 == 0);
			tx_max_gap = (ph == 2 || ph == 5) ? 0 : 5;
			rx_max_gap = (ph == 2 || ph == 5 || ph == 6) ? 0 : 5;
			word_count = 0;
			while (word_count < PHASE_WORDS) random_instr();
		end

		drain();
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/ild_pkg.sv
rtl/core/ild_step.sv
rtl/core/x86_instruction_length_decoder.sv
tb/tb_top.sv
